/* rtl/pll_divider_search_config_word_defines.svh */
// assertion macros shared by the pll divider search rtl
// depends on aclk and aresetn being in scope where a macro is used
`ifndef PLL_DIVIDER_SEARCH_CONFIG_WORD_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_CONFIG_WORD_DEFINES_SVH

// same-cycle implication
`define PDSC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDSC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pdsc_pkg.sv */
// types, microcode and constants of the pll divider search block
// no dependencies
`timescale 1ns / 1ps

package pdsc_pkg;

    // field widths
    localparam int MHZ_W  = 11;
    localparam int DIV_W  = 6;
    localparam int MULT_W = 8;
    localparam int BAUD_W = 22;
    localparam int RPT_W  = 16;

    localparam logic [3:0]  PLL_CLUSTER = 4'hE;
    localparam logic [31:0] PLL_FIXED   = 32'h8000_0005;   // bypass, recfg, cfg
    localparam logic [31:0] CORE_FIXED  = 32'hC000_0000;   // start, uart enable
    localparam logic [30:0] RPT_SCALE   = 31'd1000000;     // mhz to hz
    localparam logic [21:0] RECIP_25    = 22'd1311;        // 2^15 / 25, rounded up
    localparam logic [5:0]  REF_MHZ     = 6'd25;

    // configuration register indexes
    localparam logic [1:0] CFG_CHIP_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_BAUD_RATE    = 2'd1;

    localparam logic [3:0]  CHIP_ADDRESS_RST = 4'hF;
    localparam logic [21:0] BAUD_RATE_RST    = 22'd115200;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_PREP,
        OP_ADV,
        OP_TEST,
        OP_WAIT,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_SEARCH_GO,
        COND_DIV_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef logic [2:0] upc_t;

    // program addresses
    localparam upc_t STEP_LOAD = 3'd0;
    localparam upc_t STEP_INIT = 3'd1;
    localparam upc_t STEP_PREP = 3'd2;
    localparam upc_t STEP_ADV  = 3'd3;
    localparam upc_t STEP_TEST = 3'd4;
    localparam upc_t STEP_WAIT = 3'd5;
    localparam upc_t STEP_EMIT = 3'd6;

    // cond true: jump to target; false: hold or fall through
    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
        logic  hold;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic search_go;
        logic rpt_done;
        logic out_free;
    } seq_status_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_RUN,
        D_DONE
    } div_state_t;

    // microcode rom
    function automatic ctrl_word_t pdsc_ucode(input upc_t addr);
        ctrl_word_t cw;
        case (addr)
            STEP_LOAD: cw = '{OP_LOAD, COND_IN_VALID,  STEP_INIT, 1'b1};
            STEP_INIT: cw = '{OP_INIT, COND_ALWAYS,    STEP_PREP, 1'b0};
            STEP_PREP: cw = '{OP_PREP, COND_ALWAYS,    STEP_ADV,  1'b0};
            STEP_ADV:  cw = '{OP_ADV,  COND_ALWAYS,    STEP_TEST, 1'b0};
            STEP_TEST: cw = '{OP_TEST, COND_SEARCH_GO, STEP_ADV,  1'b0};
            STEP_WAIT: cw = '{OP_WAIT, COND_DIV_DONE,  STEP_EMIT, 1'b1};
            STEP_EMIT: cw = '{OP_EMIT, COND_OUT_FREE,  STEP_LOAD, 1'b1};
            default:   cw = '{OP_NOP,  COND_ALWAYS,    STEP_LOAD, 1'b0};
        endcase
        return cw;
    endfunction

endpackage

/* rtl/pdsc_sequencer.sv */
// microcode sequencer: step counter, control rom and conditional jumps
// depends on pdsc_pkg
`timescale 1ns / 1ps

module pdsc_sequencer
    import pdsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output op_t         op
);

    upc_t       upc_reg;
    upc_t       upc_next;
    ctrl_word_t cw;
    logic       cond_true;

    assign cw = pdsc_ucode(upc_reg);
    assign op = cw.op;

    always_comb begin
        case (cw.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_IN_VALID:  cond_true = status.in_valid;
            COND_SEARCH_GO: cond_true = status.search_go;
            COND_DIV_DONE:  cond_true = status.rpt_done;
            COND_OUT_FREE:  cond_true = status.out_free;
            default:        cond_true = 1'b0;
        endcase
        if (cond_true) begin
            upc_next = cw.target;
        end else if (cw.hold) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_LOAD;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* rtl/pdsc_search_dp.sv */
// divider search datapath: running quotient, cross-multiplied compares
// depends on pdsc_pkg
`timescale 1ns / 1ps

module pdsc_search_dp
    import pdsc_pkg::*;
#(
    parameter int MAX_DIVIDER    = 32,
    parameter int MAX_MULTIPLIER = 128
) (
    input  logic              aclk,
    input  op_t               op,
    input  logic              in_fire,
    input  logic [MHZ_W-1:0]  target_mhz,
    output logic [MHZ_W-1:0]  mhz,
    output logic [DIV_W-1:0]  chosen_divider,
    output logic [MULT_W-1:0] chosen_multiplier,
    output logic              search_go
);

    localparam logic [DIV_W-1:0]  MAX_DIV  = DIV_W'(MAX_DIVIDER);
    localparam logic [DIV_W-1:0]  EXH_DIV  = DIV_W'(MAX_DIVIDER + 1);
    localparam logic [MULT_W-1:0] MAX_MULT = MULT_W'(MAX_MULTIPLIER);

    logic [MHZ_W-1:0]  mhz_reg, mhz_next;
    logic [6:0]        mq_reg, mq_next;         // mhz / 25
    logic [4:0]        mr_reg, mr_next;         // mhz % 25
    logic [11:0]       q_reg, q_next;           // mhz * div / 25
    logic [4:0]        r_reg, r_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic signed [17:0] lim_acc_reg, lim_acc_next;  // (2*mhz - 1) * div
    logic [MULT_W-1:0] last_mult_reg, last_mult_next;
    logic              have_last_reg, have_last_next;
    logic [MULT_W-1:0] mult_reg, mult_next;

    logic [21:0]        recip_prod;
    logic [10:0]        mq_x25;
    logic [5:0]         r_sum;
    logic               r_wrap;
    logic signed [17:0] lim;
    logic [MULT_W-1:0]  mult_cur;
    logic [13:0]        prod_last;
    logic [13:0]        prod_cur;
    logic [13:0]        mult_x50;
    logic               step_back;
    logic               hit;

    assign recip_prod = 22'(mhz_reg) * RECIP_25;
    assign mq_x25     = 11'({mq_reg, 4'b0}) + 11'({mq_reg, 3'b0}) + 11'(mq_reg);
    assign r_sum      = 6'(r_reg) + 6'(mr_reg);
    assign r_wrap     = (r_sum >= REF_MHZ);
    assign lim        = $signed({6'b0, mhz_reg, 1'b0}) - 18'sd1;
    assign mult_cur   = (q_reg > 12'(MAX_MULT)) ? MAX_MULT : q_reg[MULT_W-1:0];
    assign prod_last  = 14'(last_mult_reg) * 14'(div_reg);
    assign prod_cur   = 14'(mult_cur) * 14'(div_reg - 6'd1);
    assign mult_x50   = 14'({mult_cur, 5'b0}) + 14'({mult_cur, 4'b0})
                      + 14'({mult_cur, 1'b0});
    assign step_back  = have_last_reg && (prod_last > prod_cur);
    assign hit        = $signed({4'b0, mult_x50}) > lim_acc_reg;

    always_comb begin
        mhz_next       = mhz_reg;
        mq_next        = mq_reg;
        mr_next        = mr_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        div_next       = div_reg;
        lim_acc_next   = lim_acc_reg;
        last_mult_next = last_mult_reg;
        have_last_next = have_last_reg;
        mult_next      = mult_reg;
        search_go      = 1'b0;
        case (op)
            OP_LOAD: begin
                if (in_fire) begin
                    mhz_next = target_mhz;
                end
            end
            OP_INIT: begin
                mq_next        = recip_prod[21:15];
                q_next         = '0;
                r_next         = '0;
                div_next       = '0;
                lim_acc_next   = '0;
                have_last_next = 1'b0;
            end
            OP_PREP: begin
                mr_next = 5'(mhz_reg - mq_x25);
            end
            OP_ADV: begin
                div_next     = div_reg + 6'd1;
                q_next       = q_reg + 12'(mq_reg) + 12'(r_wrap);
                r_next       = r_wrap ? 5'(r_sum - REF_MHZ) : r_sum[4:0];
                lim_acc_next = lim_acc_reg + lim;
            end
            OP_TEST: begin
                if (step_back) begin
                    div_next  = div_reg - 6'd1;
                    mult_next = last_mult_reg;
                end else if (hit) begin
                    mult_next = mult_cur;
                end else if (div_reg == MAX_DIV) begin
                    // nothing qualified
                    div_next  = EXH_DIV;
                    mult_next = mult_cur;
                end else begin
                    last_mult_next = mult_cur;
                    have_last_next = 1'b1;
                    search_go      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mhz_reg       <= mhz_next;
        mq_reg        <= mq_next;
        mr_reg        <= mr_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        div_reg       <= div_next;
        lim_acc_reg   <= lim_acc_next;
        last_mult_reg <= last_mult_next;
        have_last_reg <= have_last_next;
        mult_reg      <= mult_next;
    end

    assign mhz               = mhz_reg;
    assign chosen_divider    = div_reg;
    assign chosen_multiplier = mult_reg;

endmodule

/* rtl/pdsc_rpt_div.sv */
// report cycle divider: mhz * 1e6 / baud, 16-bit quotient with saturation
// depends on pdsc_pkg
`timescale 1ns / 1ps

module pdsc_rpt_div
    import pdsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MHZ_W-1:0]  mhz,
    input  logic [BAUD_W-1:0] baud,
    output logic              done,
    output logic [RPT_W-1:0]  quotient,
    output logic              saturated
);

    div_state_t        state_reg, state_next;
    logic [30:0]       n_reg, n_next;
    logic [BAUD_W-1:0] rem_reg, rem_next;
    logic [RPT_W-1:0]  shift_reg, shift_next;   // low dividend bits in, quotient out
    logic [3:0]        cnt_reg, cnt_next;
    logic              sat_reg, sat_next;

    logic [BAUD_W:0]   trial;
    logic [BAUD_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, shift_reg[RPT_W-1]};
    assign diff  = trial - {1'b0, baud};
    assign fits  = (trial >= {1'b0, baud});

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        if (start) begin
            n_next     = 31'(mhz) * RPT_SCALE;
            state_next = D_CHECK;
        end else begin
            case (state_reg)
                D_IDLE: begin
                end
                D_CHECK: begin
                    // quotient above 16 bits iff the high part reaches baud
                    if (baud == '0 || 22'(n_reg[30:16]) >= baud) begin
                        shift_next = '1;
                        sat_next   = 1'b1;
                        state_next = D_DONE;
                    end else begin
                        rem_next   = 22'(n_reg[30:16]);
                        shift_next = n_reg[15:0];
                        cnt_next   = '0;
                        sat_next   = 1'b0;
                        state_next = D_RUN;
                    end
                end
                D_RUN: begin
                    rem_next   = fits ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
                    shift_next = {shift_reg[RPT_W-2:0], fits};
                    cnt_next   = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_next = D_DONE;
                    end
                end
                D_DONE: begin
                end
                default: begin
                    state_next = D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        sat_reg   <= sat_next;
    end

    assign done      = (state_reg == D_DONE);
    assign quotient  = shift_reg;
    assign saturated = sat_reg;

endmodule

/* rtl/pll_divider_search_config_word.sv */
// top level of the pll divider search and configuration word builder
// depends on pdsc_pkg, pdsc_sequencer, pdsc_search_dp, pdsc_rpt_div and the defines header
//
//   channel  | direction | handshake          | payload
//   s_       | in        | s_valid / s_ready  | s_target_mhz
//   m_       | out       | m_valid / m_ready  | pll and core words, address bytes, choice
//   cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// one beat at a time: how long an item takes is set by the two-step trial loop of the
// sequencer, run over k dividers tried (1 to MAX_DIVIDER), and by the 16-step report
// divider that runs beside it.
// synchronous active-low reset puts the sequencer at its load step, no clearing pass.
// a result waits in the output register; the next beat is taken meanwhile, and only
// the emit step stalls while the previous result is still held.
`timescale 1ns / 1ps
`include "pll_divider_search_config_word_defines.svh"

module pll_divider_search_config_word
    import pdsc_pkg::*;
#(
    parameter int MAX_DIVIDER    = 32,
    parameter int MAX_MULTIPLIER = 128
) (
    input  logic              aclk,
    input  logic              aresetn,

    // configuration writes
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [BAUD_W-1:0] cfg_wdata,

    // target frequency beats
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [MHZ_W-1:0]  s_target_mhz,

    // result beats
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_pll_word,
    output logic [7:0]        m_pll_address_byte,
    output logic [31:0]       m_core_word,
    output logic [3:0]        m_core_address_byte,
    output logic [DIV_W-1:0]  m_chosen_divider,
    output logic [MULT_W-1:0] m_chosen_multiplier,
    output logic              m_report_saturated
);

    // configuration registers
    logic [3:0]        chip_address_reg;
    logic [BAUD_W-1:0] baud_rate_reg;

    // sequencer and datapath wiring
    op_t               op;
    seq_status_t       status;
    logic              in_fire;
    logic              out_free;
    logic              emit_fire;
    logic [MHZ_W-1:0]  mhz;
    logic [DIV_W-1:0]  chosen_divider;
    logic [MULT_W-1:0] chosen_multiplier;
    logic              search_go;
    logic              rpt_done;
    logic [RPT_W-1:0]  rpt_count;
    logic              rpt_sat;

    // pll word fields, ored as the register expects (R can reach F's low bit)
    logic [7:0]        f_field;
    logic [7:0]        r_field;
    logic [31:0]       pll_word;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       pll_word_reg;
    logic [7:0]        pll_addr_reg;
    logic [31:0]       core_word_reg;
    logic [3:0]        core_addr_reg;
    logic [DIV_W-1:0]  div_out_reg;
    logic [MULT_W-1:0] mult_out_reg;
    logic              sat_out_reg;

    // range terms for the checks
    logic              div_ok;
    logic              mult_ok;

    // configuration port, writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_address_reg <= CHIP_ADDRESS_RST;
            baud_rate_reg    <= BAUD_RATE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHIP_ADDRESS: chip_address_reg <= cfg_wdata[3:0];
                CFG_BAUD_RATE:    baud_rate_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // handshakes
    assign s_ready   = (op == OP_LOAD);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (op == OP_EMIT) && out_free;

    assign status = '{in_valid:  s_valid,
                      search_go: search_go,
                      rpt_done:  rpt_done,
                      out_free:  out_free};

    pdsc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    pdsc_search_dp #(
        .MAX_DIVIDER    (MAX_DIVIDER),
        .MAX_MULTIPLIER (MAX_MULTIPLIER)
    ) u_search (
        .aclk              (aclk),
        .op                (op),
        .in_fire           (in_fire),
        .target_mhz        (s_target_mhz),
        .mhz               (mhz),
        .chosen_divider    (chosen_divider),
        .chosen_multiplier (chosen_multiplier),
        .search_go         (search_go)
    );

    // started together with the search, finishes long before a full search
    pdsc_rpt_div u_rpt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (op == OP_INIT),
        .mhz       (mhz),
        .baud      (baud_rate_reg),
        .done      (rpt_done),
        .quotient  (rpt_count),
        .saturated (rpt_sat)
    );

    // a zero multiplier wraps F to all ones
    assign f_field  = chosen_multiplier - 8'd1;
    assign r_field  = 8'(chosen_divider) - 8'd1;
    assign pll_word = PLL_FIXED | (32'(f_field) << 21) | (32'(r_field) << 16);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            pll_word_reg  <= pll_word;
            pll_addr_reg  <= {PLL_CLUSTER, chip_address_reg};
            core_word_reg <= CORE_FIXED | 32'(rpt_count);
            core_addr_reg <= chip_address_reg;
            div_out_reg   <= chosen_divider;
            mult_out_reg  <= chosen_multiplier;
            sat_out_reg   <= rpt_sat;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_pll_word          = pll_word_reg;
    assign m_pll_address_byte  = pll_addr_reg;
    assign m_core_word         = core_word_reg;
    assign m_core_address_byte = core_addr_reg;
    assign m_chosen_divider    = div_out_reg;
    assign m_chosen_multiplier = mult_out_reg;
    assign m_report_saturated  = sat_out_reg;

    assign div_ok  = (m_chosen_divider != 6'd0)
                  && (m_chosen_divider <= DIV_W'(MAX_DIVIDER + 1));
    assign mult_ok = (m_chosen_multiplier <= MULT_W'(MAX_MULTIPLIER));

    // checks
    `PDSC_ASSERT_NXT(a_one_beat_in_flight, in_fire, !s_ready, "beat taken while busy")
    `PDSC_ASSERT_IMP(a_div_range, m_valid, div_ok, "divider out of range")
    `PDSC_ASSERT_IMP(a_mult_range, m_valid, mult_ok, "multiplier above limit")
    `PDSC_ASSERT_IMP(a_sat_word, m_valid && m_report_saturated, &m_core_word[15:0], "clamp missing")

endmodule
